// ===== design/hyperloglog_cardinality_counter_top_assert.svh =====
// assertion macros for the cardinality counter checker
`ifndef HYPERLOGLOG_CARDINALITY_COUNTER_TOP_ASSERT_SVH
`define HYPERLOGLOG_CARDINALITY_COUNTER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define HLL_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("hll check failed");
// next-cycle implication
`define HLL_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("hll check failed");
`endif

// ===== design/hll_pkg.sv =====
// shared types and constants of the cardinality counter
package hll_pkg;
   localparam logic [1:0] FUNC_ADD      = 2'd0;
   localparam logic [1:0] FUNC_MERGE    = 2'd1;
   localparam logic [1:0] FUNC_ESTIMATE = 2'd2;
   localparam logic [1:0] FUNC_CLEAR    = 2'd3;
   localparam logic CSR_LOG2_BUCKETS = 1'b0;
   localparam logic CSR_ALPHA        = 1'b1;
   localparam logic [63:0] LN2_Q32     = 64'd2977044472;
   localparam logic [63:0] LARGE_LIMIT = 64'd614891469123651720;

   // command to the arithmetic unit
   typedef struct packed {
      logic         start;
      logic [127:0] num;
      logic [127:0] den;
      logic [63:0]  log_arg;
      logic         do_div;
   } hll_op_type;

   // response of the arithmetic unit
   typedef struct packed {
      logic         done;
      logic [127:0] quo;
      logic [63:0]  log_q32;
   } hll_res_type;
endpackage

// ===== design/hll_arith.sv =====
// shared iterative unit: 128-bit restoring divide or 32-step log2
module hll_arith (
   input  logic                 clock,
   input  logic                 reset,
   input  hll_pkg::hll_op_type  op,
   output hll_pkg::hll_res_type res
);
   import hll_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_NORM, S_SQ, S_SQ2, S_DONE
   } state_type;

   state_type    state_ff;
   logic [127:0] num_ff, den_ff, quo_ff, rem_ff;
   logic [6:0]   cnt_ff;
   logic [63:0]  x_ff;
   logic [5:0]   k_ff;
   logic [31:0]  frac_ff;
   logic [127:0] prod_ff;
   logic [1:0]   ph_ff;

   // remainder step
   logic [128:0] rem_sh;
   logic [128:0] rem_diff;
   always_comb begin
      rem_sh   = {rem_ff, num_ff[127]};
      rem_diff = rem_sh - {1'b0, den_ff};
   end

   // one 32 by 32 partial product of the mantissa square per cycle in S_SQ
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   always_comb begin
      case (ph_ff)
         2'd0: begin
            mul_a = x_ff[31:0];
            mul_b = x_ff[31:0];
         end
         2'd1: begin
            mul_a = x_ff[63:32];
            mul_b = x_ff[31:0];
         end
         default: begin
            mul_a = x_ff[63:32];
            mul_b = x_ff[63:32];
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // square of the mantissa, rescaled to Q2.62
   logic [63:0] x_sq;
   always_comb begin
      x_sq = {prod_ff[125:64], prod_ff[63:62]};
   end

   // state machine of the divide, the leading one position (one bit per cycle in S_NORM) and the squaring steps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (op.start) begin
                  num_ff  <= op.num;
                  den_ff  <= op.den;
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  cnt_ff  <= '0;
                  x_ff    <= op.log_arg;
                  k_ff    <= 6'd63;
                  frac_ff <= '0;
                  ph_ff   <= '0;
                  state_ff <= op.do_div ? S_DIV : S_NORM;
               end
            end
            S_DIV: begin
               num_ff <= {num_ff[126:0], 1'b0};
               if (!rem_diff[128]) begin
                  rem_ff <= rem_diff[127:0];
                  quo_ff <= {quo_ff[126:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh[127:0];
                  quo_ff <= {quo_ff[126:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd127) begin
                  state_ff <= S_DONE;
               end
            end
            S_NORM: begin
               if (x_ff[63] || k_ff == 6'd0) begin
                  // x = v normalized to Q2.62
                  x_ff   <= x_ff >> 1;
                  cnt_ff <= '0;
                  state_ff <= S_SQ;
               end else begin
                  x_ff <= x_ff << 1;
                  k_ff <= k_ff - 6'd1;
               end
            end
            // low square, cross term twice, high square
            S_SQ: begin
               case (ph_ff)
                  2'd0: prod_ff <= {64'd0, mul_p};
                  2'd1: prod_ff <= prod_ff + ({64'd0, mul_p} << 33);
                  default: prod_ff <= prod_ff + {mul_p, 64'd0};
               endcase
               ph_ff <= (ph_ff == 2'd2) ? 2'd0 : ph_ff + 2'd1;
               if (ph_ff == 2'd2) state_ff <= S_SQ2;
            end
            S_SQ2: begin
               if (x_sq[63]) begin
                  x_ff    <= x_sq >> 1;
                  frac_ff <= {frac_ff[30:0], 1'b1};
               end else begin
                  x_ff    <= x_sq;
                  frac_ff <= {frac_ff[30:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 7'd1;
               state_ff <= (cnt_ff == 7'd31) ? S_DONE : S_SQ;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      res.done    = (state_ff == S_DONE);
      res.quo     = quo_ff;
      res.log_q32 = {26'd0, k_ff, frac_ff};
   end
endmodule

// ===== design/hyperloglog_cardinality_counter_top.sv =====
// top level of the HyperLogLog cardinality counter
//
// Add, merge and clear change the bucket store; estimate returns one result
// on rsp_valid for one cycle, which the receiver must take. Add and merge
// pass through acceptance, a memory read, then a write; a merge whose index
// is outside the buckets in use completes at acceptance. Clear, and a write
// of log2_buckets, sweep all 2^MAX_LOG2_BUCKETS entries, one per cycle.
// Estimate walks the buckets in use, then, unless the sum is zero, runs a
// 128-step restoring divide on the shared unit, and where linear counting or
// the large correction needs it, a log2 of a normalize pass plus 32 squaring
// steps, then a multiply by ln 2. busy is high from acceptance until the
// transaction completes; after reset a clearing pass holds busy high.
module hyperloglog_cardinality_counter_top #(
   parameter int MAX_LOG2_BUCKETS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_func,
   input  logic [63:0] req_hash,
   input  logic [9:0]  req_merge_index,
   input  logic [5:0]  req_merge_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_estimate,
   output logic        rsp_used_linear_counting,
   output logic        rsp_used_large_correction,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);
   import hll_pkg::*;

   localparam int DEPTH = 1 << MAX_LOG2_BUCKETS;
   localparam int AW    = MAX_LOG2_BUCKETS;
   localparam int CW    = MAX_LOG2_BUCKETS + 1;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_RD, S_WR, S_EREAD, S_EWAIT, S_ESUM, S_DIV, S_DECIDE,
      S_LOG, S_MUL, S_FIN, S_OUT
   } state_type;

   state_type   state_ff;
   logic [5:0]  mem [DEPTH];
   logic [5:0]  rdata_ff;
   logic [AW:0] addr_ff;
   logic [5:0]  val_ff;
   logic [CW-1:0] zero_ff;
   logic [3:0]  b_ff;
   logic [15:0] alpha_ff;
   logic [127:0] sum_ff;
   logic [127:0] raw_ff;
   logic        lin_ff, large_ff, sat_ff;
   logic [63:0] est_ff;
   logic [127:0] prod_ff;
   logic [63:0] d_ff;
   logic        mph_ff;
   hll_op_type  op;
   hll_res_type res;

   hll_arith u_arith (.clock(clock), .reset(reset), .op(op), .res(res));

   // effective bucket bits
   logic [3:0]  b_eff;
   logic [CW-1:0] m_cnt;
   always_comb begin
      if (b_ff < 4'd4) b_eff = 4'd4;
      else if ({28'd0, b_ff} > MAX_LOG2_BUCKETS) b_eff = 4'(MAX_LOG2_BUCKETS);
      else b_eff = b_ff;
      m_cnt = CW'(1) << b_eff;
   end

   // rank of an add transaction
   logic [63:0] shifted;
   logic [5:0]  rank;
   logic [AW-1:0] add_idx;
   always_comb begin
      shifted = req_hash >> b_eff;
      rank = 6'd1;
      if (shifted == '0) rank = 6'(7'd65 - {3'd0, b_eff});
      else begin
         for (int i = 63; i >= 0; i--) begin
            if (shifted[i]) rank = 6'(i + 1);
         end
      end
      add_idx = AW'(req_hash & 64'((64'd1 << b_eff) - 64'd1));
   end

   // merge index within the buckets in use
   logic merge_ok;
   always_comb begin
      merge_ok = ({22'd0, req_merge_index} < 32'(m_cnt));
   end

   // one term of the sum
   logic [127:0] term;
   always_comb begin
      term = (rdata_ff <= 6'd48) ? (128'd1 << (6'd48 - rdata_ff)) : '0;
   end

   logic [63:0] alpha_mm;
   always_comb begin
      alpha_mm = {48'd0, alpha_ff} << (2 * b_eff);
   end

   // end of the walk and the path the estimate takes
   logic [127:0] sum_next;
   logic         walk_last, lin_sel, mid_sel, div_go, log_go;
   always_comb begin
      sum_next  = sum_ff + term;
      walk_last = (addr_ff == m_cnt - CW'(1));
      lin_sel   = (raw_ff[127:64] == '0) && (raw_ff[63:0] <= 64'(5 * (m_cnt >> 1)));
      mid_sel   = (raw_ff[127:64] == '0) && (raw_ff[63:0] <= LARGE_LIMIT);
      div_go    = (state_ff == S_ESUM) && walk_last && (sum_next != '0);
      log_go    = (state_ff == S_DECIDE) &&
                  (lin_sel ? (zero_ff != '0) : (!mid_sel && raw_ff[127:64] == '0));
   end

   // 32 by 32 slice of d times ln 2
   logic [31:0] mul_a;
   logic [63:0] mul_p;
   always_comb begin
      mul_a = mph_ff ? d_ff[63:32] : d_ff[31:0];
      mul_p = mul_a * LN2_Q32[31:0];
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;

   always_ff @(posedge clock) begin
      if (state_ff == S_CLR) mem[addr_ff[AW-1:0]] <= '0;
      else if (state_ff == S_WR && val_ff > rdata_ff) mem[addr_ff[AW-1:0]] <= val_ff;
      rdata_ff <= mem[addr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         addr_ff   <= '0;
         b_ff      <= 4'd10;
         alpha_ff  <= 16'd47221;
         rsp_valid <= 1'b0;
         op.start  <= 1'b0;
      end else begin
         rsp_valid <= (state_ff == S_OUT);
         op.start  <= div_go || log_go;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LOG2_BUCKETS) begin
               b_ff     <= csr_data[3:0];
               addr_ff  <= '0;
               state_ff <= S_CLR;
            end else alpha_ff <= csr_data;
         end
         case (state_ff)
            S_CLR: begin
               zero_ff <= m_cnt;
               addr_ff <= addr_ff + (AW + 1)'(1);
               if (addr_ff[AW-1:0] == AW'(DEPTH - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  case (req_func)
                     FUNC_ADD: begin
                        addr_ff <= {1'b0, add_idx};
                        val_ff  <= rank;
                        state_ff <= S_RD;
                     end
                     FUNC_MERGE: begin
                        addr_ff <= {1'b0, AW'(req_merge_index)};
                        val_ff  <= req_merge_value;
                        if (merge_ok) state_ff <= S_RD;
                     end
                     FUNC_CLEAR: begin
                        addr_ff <= '0;
                        state_ff <= S_CLR;
                     end
                     default: begin
                        addr_ff <= '0;
                        sum_ff  <= '0;
                        state_ff <= S_EREAD;
                     end
                  endcase
               end
            end
            S_RD: state_ff <= S_WR;
            S_WR: begin
               if (val_ff > rdata_ff && rdata_ff == 6'd0) zero_ff <= zero_ff - CW'(1);
               state_ff <= S_IDLE;
            end
            S_EREAD: state_ff <= S_EWAIT;
            S_EWAIT: state_ff <= S_ESUM;
            S_ESUM: begin
               sum_ff <= sum_next;
               if (walk_last) begin
                  state_ff <= S_DIV;
                  // hand the divide of a nonzero sum to the shared unit next cycle
               end else begin
                  addr_ff  <= addr_ff + (AW + 1)'(1);
                  state_ff <= S_EWAIT;
               end
            end
            S_DIV: begin
               if (!op.start && !res.done && sum_ff == '0) begin
                  raw_ff   <= '1;
                  state_ff <= S_DECIDE;
               end else if (res.done) begin
                  raw_ff   <= res.quo;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               lin_ff   <= lin_sel;
               large_ff <= !lin_sel && !mid_sel;
               if (lin_sel) begin
                  if (zero_ff == '0) begin
                     sat_ff <= 1'b1; est_ff <= '1; state_ff <= S_OUT;
                  end else begin
                     sat_ff     <= 1'b0;
                     op.do_div  <= 1'b0;
                     op.log_arg <= 64'(zero_ff);
                     state_ff   <= S_LOG;
                  end
               end else if (mid_sel) begin
                  sat_ff <= 1'b0; est_ff <= raw_ff[63:0]; state_ff <= S_OUT;
               end else if (raw_ff[127:64] != '0) begin
                  sat_ff <= 1'b1; est_ff <= '1; state_ff <= S_OUT;
               end else begin
                  sat_ff     <= 1'b0;
                  op.do_div  <= 1'b0;
                  op.log_arg <= 64'd0 - raw_ff[63:0];
                  state_ff   <= S_LOG;
               end
            end
            S_LOG: begin
               if (res.done) begin
                  d_ff <= lin_ff ? (({60'd0, b_eff} << 32) - res.log_q32)
                                 : ((64'd64 << 32) - res.log_q32);
                  mph_ff   <= 1'b0;
                  state_ff <= S_MUL;
               end
            end
            // low half of d, then high half shifted up
            S_MUL: begin
               if (!mph_ff) begin
                  prod_ff <= {64'd0, mul_p};
                  mph_ff  <= 1'b1;
               end else begin
                  prod_ff  <= prod_ff + {32'd0, mul_p, 32'd0};
                  mph_ff   <= 1'b0;
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (lin_ff) begin
                  est_ff <= 64'(((prod_ff << b_eff) + {64'd0, 1'b1, 63'd0}) >> 64);
               end else if (prod_ff[127:64] != '0) begin
                  sat_ff <= 1'b1; est_ff <= '1;
               end else est_ff <= prod_ff[63:0];
               state_ff <= S_OUT;
            end
            S_OUT: begin
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // kick the divide when the walk ends with a nonzero sum
         if (div_go) begin
            op.do_div <= 1'b1;
            op.num    <= {alpha_mm >> 32, alpha_mm[31:0], 32'd0} + (sum_next >> 1);
            op.den    <= sum_next;
         end
      end
   end

   assign rsp_estimate              = est_ff;
   assign rsp_used_linear_counting  = lin_ff;
   assign rsp_used_large_correction = large_ff;
   assign rsp_saturated             = sat_ff;
endmodule

// ===== design/hll_checker.sv =====
// port-level checker for the cardinality counter, bound to the top level
`include "hyperloglog_cardinality_counter_top_assert.svh"
module hll_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic [1:0] req_func,
   input logic rsp_valid,
   input logic rsp_used_linear_counting,
   input logic rsp_used_large_correction,
   input logic rsp_saturated,
   input logic csr_valid,
   input logic csr_ready
);
   import hll_pkg::*;
   `HLL_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy && req_func != FUNC_MERGE, busy)
   `HLL_ASSERT_IMPL(a_no_csr_busy, clock, reset, busy, !csr_ready)
   `HLL_ASSERT_IMPL(a_flags_excl, clock, reset, rsp_valid, !(rsp_used_linear_counting && rsp_used_large_correction))
   `HLL_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

bind hyperloglog_cardinality_counter_top hll_checker u_hll_checker (.*);

// ===== tb/testbench.sv =====
// self-checking testbench for the cardinality counter top level
`timescale 1ns / 100ps

module testbench;
   import hll_pkg::*;

   // bucket store mirror and estimate calculator
   class cardinality_scoreboard;
      logic [5:0]   buckets[1024];
      logic [10:0]  zero_count;
      logic [3:0]   log2_reg;
      logic [15:0]  alpha_reg;
      logic [66:0]  estimate_fifo[$];
      int           mismatches;

      function new();
         log2_reg = 4'd10;
         alpha_reg = 16'd47221;
         mismatches = 0;
         wipe();
      endfunction

      function int eff_log2();
         if (log2_reg < 4) return 4;
         if (log2_reg > 10) return 10;
         return log2_reg;
      endfunction

      function void wipe();
         foreach (buckets[i]) buckets[i] = '0;
         zero_count = 11'(1 << eff_log2());
      endfunction

      function void raise(int idx, logic [5:0] val);
         if (val > buckets[idx]) begin
            if (buckets[idx] == 0) zero_count--;
            buckets[idx] = val;
         end
      endfunction

      // truncated log2 in q.32 via square-and-compare
      function logic [63:0] log2_q32(logic [63:0] v);
         int           k;
         logic [63:0]  x;
         logic [31:0]  frac;
         logic [127:0] sq;
         k = 0;
         for (int i = 63; i >= 0; i--) begin
            if (v[i] && k == 0) k = i;
         end
         x = (k <= 62) ? v << (62 - k) : v >> 1;
         frac = '0;
         for (int i = 0; i < 32; i++) begin
            sq = x * x;
            x = sq[125:62];
            frac = frac << 1;
            if (x[63]) begin
               frac[0] = 1'b1;
               x = x >> 1;
            end
         end
         return {k[31:0], frac};
      endfunction

      function void write_csr(logic [0:0] idx, logic [15:0] data);
         if (idx == CSR_LOG2_BUCKETS) begin
            log2_reg = data[3:0];
            wipe();
         end else alpha_reg = data;
      endfunction

      // one accepted command transaction
      function void note_input(logic [1:0] func, logic [63:0] hash,
                               logic [9:0] midx, logic [5:0] mval);
         int           b;
         int           m;
         int           rank;
         logic [63:0]  s;
         logic [127:0] sum, num, raw, p;
         logic [63:0]  a, est, d, y;
         logic         lin, large_corr, sat;
         b = eff_log2();
         m = 1 << b;
         case (func)
            FUNC_ADD: begin
               s = hash >> b;
               if (s == 0) rank = 65 - b;
               else begin
                  rank = 1;
                  while (!s[0]) begin
                     s = s >> 1;
                     rank++;
                  end
               end
               raise(int'(hash & 64'(m - 1)), 6'(rank));
            end
            FUNC_MERGE: if (midx < m) raise(midx, mval);
            FUNC_CLEAR: wipe();
            default: begin
               sum = '0;
               for (int i = 0; i < m; i++) begin
                  if (buckets[i] <= 48) sum = sum + (128'd1 << (48 - buckets[i]));
               end
               if (sum == 0) raw = '1;
               else begin
                  a = 64'(alpha_reg) * 64'(m) * 64'(m);
                  num = ({64'd0, a} << 32) + (sum >> 1);
                  raw = num / sum;
               end
               lin = 0; large_corr = 0; sat = 0; est = '0;
               if (raw <= 128'(5 * (m >> 1))) begin
                  lin = 1;
                  if (zero_count == 0) begin
                     sat = 1;
                     est = '1;
                  end else begin
                     d = (64'(b) << 32) - log2_q32(64'(zero_count));
                     p = ({64'd0, d} * {64'd0, LN2_Q32}) << b;
                     p = p + (128'd1 << 63);
                     est = p[127:64];
                  end
               end else if (raw <= {64'd0, LARGE_LIMIT}) begin
                  est = raw[63:0];
               end else begin
                  large_corr = 1;
                  if (raw[127:64] != 0) begin
                     sat = 1;
                     est = '1;
                  end else begin
                     y = 64'd0 - raw[63:0];
                     p = {64'd0, (64'd64 << 32) - log2_q32(y)} * {64'd0, LN2_Q32};
                     if (p[127:64] != 0) begin
                        sat = 1;
                        est = '1;
                     end else est = p[63:0];
                  end
               end
               estimate_fifo.push_back({est, lin, large_corr, sat});
            end
         endcase
      endfunction

      // compare one result transaction with the oldest prediction
      function void check_result(logic [63:0] est, logic lin, logic large_corr, logic sat);
         logic [66:0] exp_r;
         if (estimate_fifo.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: estimate=%0d", est);
            return;
         end
         exp_r = estimate_fifo.pop_front();
         if (exp_r !== {est, lin, large_corr, sat}) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp est=%0d lin=%0b large=%0b sat=%0b got est=%0d lin=%0b large=%0b sat=%0b",
                        exp_r[66:3], exp_r[2], exp_r[1], exp_r[0], est, lin, large_corr, sat);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [63:0] req_hash;
   logic [9:0]  req_merge_index;
   logic [5:0]  req_merge_value;
   logic        rsp_valid;
   logic [63:0] rsp_estimate;
   logic        rsp_used_linear_counting;
   logic        rsp_used_large_correction;
   logic        rsp_saturated;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [15:0] csr_data;

   cardinality_scoreboard sb = new();
   int idle_pct;

   hyperloglog_cardinality_counter_top u_top (.*);

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // monitors see pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.write_csr(csr_index, csr_data);
         if (start && !busy)
            sb.note_input(req_func, req_hash, req_merge_index, req_merge_value);
         if (rsp_valid)
            sb.check_result(rsp_estimate, rsp_used_linear_counting,
                            rsp_used_large_correction, rsp_saturated);
      end
   end

   // issue one command transaction, with an optional gap first
   task automatic send_cmd(logic [1:0] func, logic [63:0] hash,
                           logic [9:0] midx, logic [5:0] mval);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= func;
      req_hash <= hash;
      req_merge_index <= midx;
      req_merge_value <= mval;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // wait until the block is quiet and no estimate is outstanding
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.estimate_fifo.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [0:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one random command, biased toward adds with deep ranks
   task automatic random_cmd();
      int          r;
      int          m;
      logic [63:0] h;
      logic [9:0]  idx;
      r = $urandom_range(99);
      m = 1 << sb.eff_log2();
      h = {$urandom, $urandom};
      if (r < 70) begin
         if ($urandom_range(19) == 0) h = h & 64'(m - 1);
         else if ($urandom_range(1)) h = h << $urandom_range(63);
         send_cmd(FUNC_ADD, h, 10'($urandom), 6'($urandom));
      end else if (r < 83) begin
         idx = $urandom_range(9) == 0 ? 10'($urandom) : 10'($urandom_range(m - 1));
         send_cmd(FUNC_MERGE, h, idx, 6'($urandom_range(61)));
      end else if (r < 95) send_cmd(FUNC_ESTIMATE, h, 10'($urandom), 6'($urandom));
      else send_cmd(FUNC_CLEAR, h, 10'($urandom), 6'($urandom));
   endtask

   initial begin
      logic [3:0]  log2_set[6];
      logic [15:0] alpha_set[6];
      int          idle_set[4];
      log2_set = '{4'd4, 4'd0, 4'd15, 4'd7, 4'd10, 4'd5};
      alpha_set = '{16'd45220, 16'd0, 16'd65535, 16'd46500, 16'd47221, 16'd45740};
      idle_set = '{0, 60, 0, 29};
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_ADD;
      req_hash = '0;
      req_merge_index = '0;
      req_merge_value = '0;
      csr_valid = 1'b0;
      csr_index = CSR_LOG2_BUCKETS;
      csr_data = '0;
      idle_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, extremes of the hash and merge fields
      send_cmd(FUNC_ESTIMATE, '0, '0, '0);
      send_cmd(FUNC_ADD, 64'd0, '0, '0);
      send_cmd(FUNC_ADD, '1, '1, '1);
      send_cmd(FUNC_ADD, 64'h8000_0000_0000_0155, '0, '0);
      send_cmd(FUNC_MERGE, '0, 10'd1023, 6'd61);
      send_cmd(FUNC_MERGE, '0, 10'd5, 6'd0);
      send_cmd(FUNC_ESTIMATE, '0, '0, '0);
      send_cmd(FUNC_CLEAR, '0, '0, '0);
      send_cmd(FUNC_ESTIMATE, '0, '0, '0);
      drain();
      // smallest store: ignored merge index, then every bucket above the sum range
      csr_write(CSR_LOG2_BUCKETS, 16'hfff4);
      csr_write(CSR_ALPHA, 16'd45220);
      send_cmd(FUNC_MERGE, '0, 10'd500, 6'd40);
      for (int i = 0; i < 16; i++) send_cmd(FUNC_MERGE, '0, 10'(i), 6'd61);
      send_cmd(FUNC_ESTIMATE, '0, '0, '0);
      drain();

      // random phases over several settings and idle patterns
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_LOG2_BUCKETS, {12'($urandom), log2_set[ph]});
         csr_write(CSR_ALPHA, alpha_set[ph]);
         for (int q = 0; q < 4; q++) begin
            idle_pct = idle_set[q];
            for (int n = 0; n < 73; n++) random_cmd();
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (sb.mismatches == 0 && sb.estimate_fifo.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+design
design/hll_pkg.sv
design/hll_arith.sv
design/hyperloglog_cardinality_counter_top.sv
design/hll_checker.sv
tb/testbench.sv
